// ===== hw/rtl/scr_pkg.sv =====
// Shared constants, types and helpers for the stick relaxation core.
package scr_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int MAX_STICKS    = 128;
    localparam int SLEEP_LIMIT   = 3;

    localparam int PART_AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int STICK_AW = (MAX_STICKS > 1) ? $clog2(MAX_STICKS) : 1;
    localparam int PCNT_W   = $clog2(MAX_PARTICLES + 1);
    localparam int SCNT_W   = $clog2(MAX_STICKS + 1);

    localparam int WORD_W     = 32;
    localparam int VEC_W      = 3 * WORD_W;
    localparam int LEN_W      = 31;
    localparam int END_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 24;

    // shared multiplier
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // iterative divider and root
    localparam int DVD_W      = 64;
    localparam int DVS_W      = 33;
    localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

    typedef enum logic [1:0] {
        KIND_PARTICLE = 2'd0,
        KIND_STICK    = 2'd1,
        KIND_RUN      = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STK_NORMAL   = 2'd0,
        STK_MIN_DIST = 2'd1,
        STK_CLOTH    = 2'd2
    } stk_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP   = 3'd0,
        CFG_ITER   = 3'd1,
        CFG_PCOUNT = 3'd2,
        CFG_SCOUNT = 3'd3,
        CFG_SLEEP  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]       stype;
        logic [END_W-1:0] eb;
        logic [END_W-1:0] ea;
        logic [LEN_W-1:0] len;
    } stick_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PRED_RD, ST_PRED_MUL, ST_PRED_ADD, ST_PRED_WR,
        ST_RLX_RD, ST_RLX_CHK, ST_RLX_RDB, ST_RLX_DIF, ST_RLX_SQ, ST_RLX_ACC,
        ST_RLX_Q, ST_RLX_QW, ST_RLX_SQRT, ST_RLX_NMUL, ST_RLX_NDIV, ST_RLX_NWAIT,
        ST_RLX_NORM, ST_RLX_CDIV, ST_RLX_CMUL, ST_RLX_CSH, ST_RLX_UPDA,
        ST_RLX_UPDB, ST_RLX_NEXT, ST_WB_RD, ST_WB_DIV, ST_WB_WAIT, ST_WB_WR,
        ST_EMIT_RD, ST_EMIT_LD
    } state_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        if (x > 68'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -68'sd2147483648)
            return 32'sh80000000;
        else
            return x[WORD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/scr_div.sv =====
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module scr_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [scr_pkg::DVD_W-1:0]   num,
    input  logic        [scr_pkg::DVS_W-1:0]   den,
    output logic                               busy,
    output logic                               done,
    output logic signed [scr_pkg::DVD_W-1:0]   quot
);
    import scr_pkg::*;

    logic [DVD_W-1:0]     dvd_reg;
    logic [DVS_W:0]       rem_reg;
    logic [DVS_W-1:0]     den_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DVS_W:0]       rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= num[DVD_W-1] ? DVD_W'(-num) : DVD_W'(num);
            neg_reg <= num[DVD_W-1];
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);

endmodule

// ===== hw/rtl/scr_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module scr_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [scr_pkg::RAD_W-1:0]    rad,
    output logic                         done,
    output logic [scr_pkg::ROOT_W-1:0]   root
);
    import scr_pkg::*;

    logic [RAD_W-1:0]      rad_reg;
    logic [ROOT_W+2:0]     rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [ROOT_W+2:0]     rem_sh;
    logic [ROOT_W+2:0]     trial;
    logic                  fits;

    assign rem_sh = {rem_reg[ROOT_W:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQRT_CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQRT_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/stick_constraint_relaxation_core.sv =====
// Top level of the stick constraint relaxation core: stores, sequencer, shared math.
// Load requests (particle or stick) are taken while idle and write the on-chip stores
// directly. A run request predicts every particle, relaxes every stick for the
// configured number of passes, then turns positions back into velocities (three
// divides per particle) and streams one result per particle. A normal or
// minimum-distance stick costs a square root plus three divides, a cloth stick one
// divide plus its normalizing shifts. The restoring divider dominates everything. While
// asleep (sleep_frames of 3 or more) or with a zero step, a run only streams the stored
// velocities. There is no clearing pass: a store entry that was never loaded reads as
// garbage. Configuration is a plain write port and must only be touched while the core
// is idle with no result pending.
module stick_constraint_relaxation_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [scr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [scr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           kind,
    input  logic [6:0]                           index,
    input  logic signed [31:0]                   pos_x,
    input  logic signed [31:0]                   pos_y,
    input  logic signed [31:0]                   pos_z,
    input  logic signed [31:0]                   vel_x,
    input  logic signed [31:0]                   vel_y,
    input  logic signed [31:0]                   vel_z,
    input  logic [1:0]                           stick_type,
    input  logic [5:0]                           end_a,
    input  logic [5:0]                           end_b,
    input  logic [30:0]                          rest_length,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [5:0]                           particle_index,
    output logic signed [31:0]                   new_vel_x,
    output logic signed [31:0]                   new_vel_y,
    output logic signed [31:0]                   new_vel_z,
    output logic                                 last
);
    import scr_pkg::*;

    // configuration
    logic [STEP_W-1:0] step_reg;
    logic [7:0]        iter_cfg_reg;
    logic [6:0]        pcount_reg;
    logic [7:0]        scount_reg;
    logic [7:0]        sleep_reg;

    // sequencer
    state_t               state_reg, state_next;
    logic [PART_AW-1:0]   pidx_reg, pidx_next;
    logic [STICK_AW-1:0]  s_reg, s_next;
    logic [7:0]           it_reg, it_next;
    logic [1:0]           k_reg, k_next;

    // stores
    logic [VEC_W-1:0] orig_mem [MAX_PARTICLES];
    logic [VEC_W-1:0] vel_mem  [MAX_PARTICLES];
    logic [VEC_W-1:0] fut_mem  [MAX_PARTICLES];
    stick_t           stk_mem  [MAX_STICKS];
    logic [VEC_W-1:0] orig_q, vel_q, fut_q;
    stick_t           stk_q;

    logic                 part_re, fut_re, stk_re;
    logic [PART_AW-1:0]   fut_ra;
    logic                 orig_we, vel_we, fut_we, stk_we;
    logic [PART_AW-1:0]   vel_wa, fut_wa;
    logic [VEC_W-1:0]     vel_wd, fut_wd;

    // datapath
    logic [VEC_W-1:0]         vec_reg;
    logic [VEC_W-1:0]         fa_reg, fb_reg;
    logic signed [WORD_W-1:0] v_reg [3];
    logic signed [WORD_W:0]   off_reg [3];
    logic [DVD_W-1:0]         d_reg;
    logic [RAD_W-1:0]         a_reg, b_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic signed [MUL_W-1:0]  diff_reg;
    logic signed [30:0]       f_reg;

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p_reg;

    // divider and root
    logic                     div_start, div_busy, div_done;
    logic signed [DVD_W-1:0]  div_num, div_quot;
    logic [DVS_W-1:0]         div_den;
    logic                     sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;

    // output register
    logic                     out_load;
    logic                     out_valid_reg;
    logic [5:0]               pidx_out_reg;
    logic [VEC_W-1:0]         vel_out_reg;
    logic                     last_reg;

    // helpers
    logic [PCNT_W-1:0]        np;
    logic [SCNT_W-1:0]        ns;
    logic                     active;
    logic                     last_part, last_stick, last_iter;
    logic                     stick_skip;
    logic signed [WORD_W-1:0] vel_k, orig_k, fut_k;
    logic signed [PROD_W-1:0] pred_trunc, cloth_trunc;
    logic [VEC_W-1:0]         upd_a, upd_b;
    logic signed [30:0]       cloth_nd;
    logic [30:0]              cloth_sum;
    logic signed [WORD_W:0]   wb_df;

    assign np = (32'(pcount_reg) > MAX_PARTICLES) ? PCNT_W'(MAX_PARTICLES)
                                                  : PCNT_W'(pcount_reg);
    assign ns = (32'(scount_reg) > MAX_STICKS) ? SCNT_W'(MAX_STICKS)
                                               : SCNT_W'(scount_reg);
    assign active     = (step_reg != '0) && (32'(sleep_reg) < SLEEP_LIMIT);
    assign last_part  = (32'(pidx_reg) + 1) == 32'(np);
    assign last_stick = (32'(s_reg) + 1) == 32'(ns);
    assign last_iter  = (9'(it_reg) + 9'd1) == 9'(iter_cfg_reg);

    // ends outside particles in use or undefined type: skip
    assign stick_skip = (32'(stk_q.ea) >= 32'(np)) || (32'(stk_q.eb) >= 32'(np)) ||
                        (stk_q.stype > STK_CLOTH);

    assign vel_k  = $signed(vel_q[k_reg*WORD_W +: WORD_W]);
    assign orig_k = $signed(orig_q[k_reg*WORD_W +: WORD_W]);
    assign fut_k  = $signed(fut_q[k_reg*WORD_W +: WORD_W]);

    // divide by 2^16 / 2^30 rounding toward zero
    assign pred_trunc  = (mul_p_reg + (mul_p_reg[PROD_W-1] ? 68'sd65535 : 68'sd0)) >>> 16;
    assign cloth_trunc = (mul_p_reg + (mul_p_reg[PROD_W-1] ? 68'sd1073741823 : 68'sd0))
                         >>> 30;

    assign cloth_nd  = $signed({1'b0, b_reg[29:0]}) - $signed({1'b0, a_reg[29:0]});
    assign cloth_sum = {1'b0, a_reg[29:0]} + {1'b0, b_reg[29:0]};
    assign wb_df     = 33'(fut_k) - 33'(orig_k);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            upd_a[i*WORD_W +: WORD_W] = sat32(68'($signed(fa_reg[i*WORD_W +: WORD_W]))
                                              - 68'(off_reg[i]));
            upd_b[i*WORD_W +: WORD_W] = sat32(68'($signed(fb_reg[i*WORD_W +: WORD_W]))
                                              + 68'(off_reg[i]));
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_W'(1092);
            iter_cfg_reg <= 8'd1;
            pcount_reg   <= '0;
            scount_reg   <= '0;
            sleep_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_STEP:   step_reg     <= cfg_data[STEP_W-1:0];
                CFG_ITER:   iter_cfg_reg <= cfg_data[7:0];
                CFG_PCOUNT: pcount_reg   <= cfg_data[6:0];
                CFG_SCOUNT: scount_reg   <= cfg_data[7:0];
                CFG_SLEEP:  sleep_reg    <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pidx_reg  <= '0;
            s_reg     <= '0;
            it_reg    <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pidx_reg  <= pidx_next;
            s_reg     <= s_next;
            it_reg    <= it_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pidx_next  = pidx_reg;
        s_next     = s_reg;
        it_next    = it_reg;
        k_next     = k_reg;
        in_ready   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        sqrt_start = 1'b0;
        part_re    = 1'b0;
        fut_re     = 1'b0;
        fut_ra     = pidx_reg;
        stk_re     = 1'b0;
        orig_we    = 1'b0;
        vel_we     = 1'b0;
        vel_wa     = pidx_reg;
        vel_wd     = vec_reg;
        fut_we     = 1'b0;
        fut_wa     = pidx_reg;
        fut_wd     = vec_reg;
        stk_we     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                vel_wa   = PART_AW'(index);
                vel_wd   = {vel_z, vel_y, vel_x};
                if (in_valid)
                begin
                    case (kind_t'(kind))
                        KIND_PARTICLE:
                        begin
                            if (32'(index) < 32'(np))
                            begin
                                orig_we = 1'b1;
                                vel_we  = 1'b1;
                            end
                        end
                        KIND_STICK:
                        begin
                            if (32'(index) < 32'(ns))
                                stk_we = 1'b1;
                        end
                        KIND_RUN:
                        begin
                            pidx_next = '0;
                            if (np != '0)
                                state_next = active ? ST_PRED_RD : ST_EMIT_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PRED_RD:
            begin
                part_re    = 1'b1;
                k_next     = '0;
                state_next = ST_PRED_MUL;
            end
            ST_PRED_MUL:
            begin
                mul_a      = $signed({{(MUL_W-STEP_W){1'b0}}, step_reg});
                mul_b      = MUL_W'(vel_k);
                state_next = ST_PRED_ADD;
            end
            ST_PRED_ADD:
            begin
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? ST_PRED_WR : ST_PRED_MUL;
            end
            ST_PRED_WR:
            begin
                fut_we = 1'b1;
                if (last_part)
                begin
                    s_next    = '0;
                    it_next   = '0;
                    pidx_next = '0;
                    state_next = (iter_cfg_reg == '0 || ns == '0) ? ST_WB_RD : ST_RLX_RD;
                end
                else
                begin
                    pidx_next  = pidx_reg + 1'b1;
                    state_next = ST_PRED_RD;
                end
            end
            ST_RLX_RD:
            begin
                stk_re     = 1'b1;
                state_next = ST_RLX_CHK;
            end
            ST_RLX_CHK:
            begin
                fut_ra = PART_AW'(stk_q.ea);
                if (stick_skip)
                    state_next = ST_RLX_NEXT;
                else
                begin
                    fut_re     = 1'b1;
                    state_next = ST_RLX_RDB;
                end
            end
            ST_RLX_RDB:
            begin
                fut_re     = 1'b1;
                fut_ra     = PART_AW'(stk_q.eb);
                state_next = ST_RLX_DIF;
            end
            ST_RLX_DIF:
            begin
                k_next     = '0;
                state_next = ST_RLX_SQ;
            end
            ST_RLX_SQ:
            begin
                mul_a      = MUL_W'(v_reg[k_reg]);
                mul_b      = MUL_W'(v_reg[k_reg]);
                state_next = ST_RLX_ACC;
            end
            ST_RLX_ACC:
            begin
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? ST_RLX_Q : ST_RLX_SQ;
            end
            ST_RLX_Q:
            begin
                mul_a      = $signed({3'b000, stk_q.len});
                mul_b      = $signed({3'b000, stk_q.len});
                state_next = ST_RLX_QW;
            end
            ST_RLX_QW:
            begin
                if (d_reg == '0)
                    state_next = ST_RLX_NEXT;
                else if (stk_q.stype == STK_CLOTH)
                    state_next = ST_RLX_NORM;
                else if (stk_q.stype == STK_MIN_DIST &&
                         d_reg >= DVD_W'(mul_p_reg[2*LEN_W-1:0]))
                    state_next = ST_RLX_NEXT;
                else
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_RLX_SQRT;
                end
            end
            ST_RLX_SQRT:
            begin
                k_next = '0;
                if (sqrt_done)
                    state_next = ST_RLX_NMUL;
            end
            ST_RLX_NMUL:
            begin
                mul_a      = MUL_W'(v_reg[k_reg]);
                mul_b      = diff_reg;
                state_next = ST_RLX_NDIV;
            end
            ST_RLX_NDIV:
            begin
                div_start  = 1'b1;
                div_num    = mul_p_reg[DVD_W-1:0];
                div_den    = {root_reg, 1'b0};
                state_next = ST_RLX_NWAIT;
            end
            ST_RLX_NWAIT:
            begin
                if (div_done)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd2) ? ST_RLX_UPDA : ST_RLX_NMUL;
                end
            end
            ST_RLX_NORM:
            begin
                if (!(a_reg >= 64'd1073741824 || b_reg >= 64'd1073741824))
                begin
                    div_start  = 1'b1;
                    div_num    = {{3{cloth_nd[30]}}, cloth_nd, 30'd0};
                    div_den    = {1'b0, cloth_sum, 1'b0};
                    state_next = ST_RLX_CDIV;
                end
            end
            ST_RLX_CDIV:
            begin
                k_next = '0;
                if (div_done)
                    state_next = ST_RLX_CMUL;
            end
            ST_RLX_CMUL:
            begin
                mul_a      = MUL_W'(v_reg[k_reg]);
                mul_b      = MUL_W'(f_reg);
                state_next = ST_RLX_CSH;
            end
            ST_RLX_CSH:
            begin
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? ST_RLX_UPDA : ST_RLX_CMUL;
            end
            ST_RLX_UPDA:
            begin
                fut_we     = 1'b1;
                fut_wa     = PART_AW'(stk_q.ea);
                fut_wd     = upd_a;
                state_next = ST_RLX_UPDB;
            end
            ST_RLX_UPDB:
            begin
                fut_we     = 1'b1;
                fut_wa     = PART_AW'(stk_q.eb);
                fut_wd     = upd_b;
                state_next = ST_RLX_NEXT;
            end
            ST_RLX_NEXT:
            begin
                if (last_stick)
                begin
                    s_next = '0;
                    if (last_iter)
                    begin
                        pidx_next  = '0;
                        state_next = ST_WB_RD;
                    end
                    else
                    begin
                        it_next    = it_reg + 8'd1;
                        state_next = ST_RLX_RD;
                    end
                end
                else
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_RLX_RD;
                end
            end
            ST_WB_RD:
            begin
                part_re    = 1'b1;
                fut_re     = 1'b1;
                k_next     = '0;
                state_next = ST_WB_DIV;
            end
            ST_WB_DIV:
            begin
                div_start  = 1'b1;
                div_num    = {{15{wb_df[WORD_W]}}, wb_df, 16'd0};
                div_den    = {{(DVS_W-STEP_W){1'b0}}, step_reg};
                state_next = ST_WB_WAIT;
            end
            ST_WB_WAIT:
            begin
                if (div_done)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd2) ? ST_WB_WR : ST_WB_DIV;
                end
            end
            ST_WB_WR:
            begin
                vel_we = 1'b1;
                if (last_part)
                begin
                    pidx_next  = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    pidx_next  = pidx_reg + 1'b1;
                    state_next = ST_WB_RD;
                end
            end
            ST_EMIT_RD:
            begin
                part_re    = 1'b1;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    if (last_part)
                        state_next = ST_IDLE;
                    else
                    begin
                        pidx_next  = pidx_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // stores: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (orig_we)
            orig_mem[PART_AW'(index)] <= {pos_z, pos_y, pos_x};
        if (part_re)
            orig_q <= orig_mem[pidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (vel_we)
            vel_mem[vel_wa] <= vel_wd;
        if (part_re)
            vel_q <= vel_mem[pidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (fut_we)
            fut_mem[fut_wa] <= fut_wd;
        if (fut_re)
            fut_q <= fut_mem[fut_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[STICK_AW'(index)] <= {stick_type, end_b, end_a, rest_length};
        if (stk_re)
            stk_q <= stk_mem[s_reg];
    end

    // shared multiplier, registered
    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_PRED_ADD:
                vec_reg[k_reg*WORD_W +: WORD_W] <= sat32(68'(orig_k) + pred_trunc);
            ST_RLX_RDB:
                fa_reg <= fut_q;
            ST_RLX_DIF:
            begin
                fb_reg <= fut_q;
                d_reg  <= '0;
                for (int i = 0; i < 3; i++)
                    v_reg[i] <= sat32(68'($signed(fut_q[i*WORD_W +: WORD_W]))
                                      - 68'($signed(fa_reg[i*WORD_W +: WORD_W])));
            end
            ST_RLX_ACC:
                d_reg <= d_reg + mul_p_reg[DVD_W-1:0];
            ST_RLX_QW:
            begin
                a_reg <= d_reg;
                b_reg <= RAD_W'(mul_p_reg[2*LEN_W-1:0]);
            end
            ST_RLX_SQRT:
            begin
                if (sqrt_done)
                begin
                    root_reg <= sqrt_root;
                    diff_reg <= $signed({3'b000, stk_q.len}) - $signed({2'b00, sqrt_root});
                end
            end
            ST_RLX_NWAIT:
            begin
                if (div_done)
                    off_reg[k_reg] <= div_quot[WORD_W:0];
            end
            ST_RLX_NORM:
            begin
                if (a_reg >= 64'd1073741824 || b_reg >= 64'd1073741824)
                begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                end
            end
            ST_RLX_CDIV:
            begin
                if (div_done)
                    f_reg <= div_quot[30:0];
            end
            ST_RLX_CSH:
                off_reg[k_reg] <= cloth_trunc[WORD_W:0];
            ST_WB_WAIT:
            begin
                if (div_done)
                    vec_reg[k_reg*WORD_W +: WORD_W] <= sat32(68'(div_quot));
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pidx_out_reg <= 6'(pidx_reg);
            vel_out_reg  <= vel_q;
            last_reg     <= last_part;
        end
    end

    assign out_valid      = out_valid_reg;
    assign particle_index = pidx_out_reg;
    assign new_vel_x      = $signed(vel_out_reg[WORD_W-1:0]);
    assign new_vel_y      = $signed(vel_out_reg[2*WORD_W-1:WORD_W]);
    assign new_vel_z      = $signed(vel_out_reg[3*WORD_W-1:2*WORD_W]);
    assign last           = last_reg;

    scr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    scr_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (d_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_RLX_NWAIT || state_reg == ST_RLX_CDIV ||
                      state_reg == ST_WB_WAIT))
        else $error("quotient arrived outside a wait state");

    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == ST_RLX_SQRT)
        else $error("root arrived outside its wait state");

    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule
